// ===== hdl/ncodm_pkg.sv =====
package ncodm_pkg;

  localparam int unsigned PHASE_BITS  = 32;
  localparam int unsigned TABLE_BITS  = 8;
  localparam int unsigned QUARTER_LEN = (1 << TABLE_BITS) / 4;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned LO_BITS     = 8;
  localparam int unsigned PROD_BITS   = SAMPLE_BITS + LO_BITS;
  localparam int unsigned FILT_BITS   = 20;
  localparam int unsigned FILT_SHIFT  = 4;
  localparam int unsigned SSB_SHIFT   = 8;
  localparam int unsigned AM_SHIFT    = 9;
  localparam int unsigned AUDIO_BITS  = 12;
  localparam int unsigned PWM_BITS    = 8;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned DATA_BITS   = 32;

  localparam logic [ADDR_BITS-1:0] ADDR_PHASE_STEP = 3'd0;
  localparam logic [ADDR_BITS-1:0] ADDR_DEMOD_MODE = 3'd4;

  localparam logic [1:0] MODE_USB = 2'd0;
  localparam logic [1:0] MODE_LSB = 2'd1;

  localparam logic [TABLE_BITS-1:0] QUARTER_OFFSET = TABLE_BITS'(QUARTER_LEN);

  localparam logic [6:0] QUARTER_SINE [QUARTER_LEN+1] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
    7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
    7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
    7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
    7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
    7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
    7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
    7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd127
  };

  typedef logic [TABLE_BITS-1:0]         phase_idx_t;
  typedef logic [SAMPLE_BITS-1:0]        adc_sample_t;
  typedef logic signed [AUDIO_BITS-1:0]  audio_value_t;
  typedef logic [PWM_BITS-1:0]           pwm_level_t;
  typedef logic signed [LO_BITS-1:0]     lo_value_t;
  typedef logic signed [FILT_BITS-1:0]   filter_value_t;

  function automatic lo_value_t sine_value(input phase_idx_t idx);
    logic [TABLE_BITS-2:0] j;
    logic [6:0]            mag;
    begin
      if (idx[TABLE_BITS-2]) begin
        j = QUARTER_OFFSET[TABLE_BITS-2:0] - {1'b0, idx[TABLE_BITS-3:0]};
      end else begin
        j = {1'b0, idx[TABLE_BITS-3:0]};
      end
      mag = QUARTER_SINE[j];
      if (idx[TABLE_BITS-1]) begin
        sine_value = -signed'({1'b0, mag});
      end else begin
        sine_value = signed'({1'b0, mag});
      end
    end
  endfunction

endpackage

// ===== hdl/ncodm_in_if.sv =====
interface ncodm_in_if;
  logic                  valid;
  logic                  ready;
  ncodm_pkg::adc_sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== hdl/ncodm_out_if.sv =====
interface ncodm_out_if;
  logic                   valid;
  logic                   ready;
  ncodm_pkg::audio_value_t audio_value;
  ncodm_pkg::pwm_level_t   pwm_level;

  modport source (output valid, output audio_value, output pwm_level, input ready);
  modport sink (input valid, input audio_value, input pwm_level, output ready);
endinterface

// ===== hdl/nco_mixer_ssb_am_demodulator.sv =====
// NCO quadrature mixer with sideband and amplitude demodulation.
// adc (sink): one raw 12-bit converter sample per item, midscale 2048.
// audio (source): one result per sample, audio_value (signed 12 bits) and
// pwm_level, the low 8 bits of audio_value plus 128.
// APB port: phase_step at 0x0, demod_mode at 0x4 (0 upper sideband,
// 1 lower sideband, 2 or 3 amplitude). Write only while no item is in flight.
// A sample is accepted into the input register (phase step, table index), then the
// table lookup, multiply, filter update and combine run into the result register.
// Throughput: one item per cycle while the receiver takes each result, set by the
// single filter update per sample.
// A stalled receiver holds the result register; the input register still
// takes one more item, then adc.ready drops until the result is taken.
// Reset clears the phase accumulator, both filters, the configuration registers
// and all valid flags.
module nco_mixer_ssb_am_demodulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ncodm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ncodm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ncodm_pkg::DATA_BITS-1:0]     prdata,
  output logic                                pready,
  ncodm_in_if.sink                            adc,
  ncodm_out_if.source                         audio
);

  logic [ncodm_pkg::PHASE_BITS-1:0] phase_step;
  logic [1:0]                       demod_mode;
  logic [ncodm_pkg::PHASE_BITS-1:0] phase_accumulator;
  logic [ncodm_pkg::PHASE_BITS-1:0] phase_next;

  logic                      stage_valid;
  ncodm_pkg::adc_sample_t    stage_sample;
  ncodm_pkg::phase_idx_t     stage_idx;
  logic                      stage_advance;

  ncodm_pkg::filter_value_t  inphase_filter;
  ncodm_pkg::filter_value_t  quadrature_filter;
  ncodm_pkg::filter_value_t  inphase_next;
  ncodm_pkg::filter_value_t  quadrature_next;

  logic signed [ncodm_pkg::SAMPLE_BITS-1:0] sample;
  ncodm_pkg::lo_value_t                     lo_i;
  ncodm_pkg::lo_value_t                     lo_q;
  logic signed [ncodm_pkg::PROD_BITS-1:0]   prod_i;
  logic signed [ncodm_pkg::PROD_BITS-1:0]   prod_q;
  logic signed [ncodm_pkg::FILT_BITS:0]     diff_i;
  logic signed [ncodm_pkg::FILT_BITS:0]     diff_q;
  logic signed [ncodm_pkg::FILT_BITS:0]     step_i;
  logic signed [ncodm_pkg::FILT_BITS:0]     step_q;
  logic signed [ncodm_pkg::FILT_BITS:0]     ssb_sum;
  logic signed [ncodm_pkg::FILT_BITS:0]     ssb_diff;
  logic signed [ncodm_pkg::FILT_BITS:0]     ssb_shifted;
  logic [ncodm_pkg::FILT_BITS:0]            abs_i;
  logic [ncodm_pkg::FILT_BITS:0]            abs_q;
  logic [ncodm_pkg::FILT_BITS:0]            am_sum;
  ncodm_pkg::audio_value_t                  audio_next;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      demod_mode <= ncodm_pkg::MODE_USB;
    end else if (cfg_write) begin
      if (paddr == ncodm_pkg::ADDR_PHASE_STEP) begin
        phase_step <= pwdata;
      end
      if (paddr == ncodm_pkg::ADDR_DEMOD_MODE) begin
        demod_mode <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ncodm_pkg::ADDR_PHASE_STEP: prdata = phase_step;
      ncodm_pkg::ADDR_DEMOD_MODE: prdata = {{(ncodm_pkg::DATA_BITS-2){1'b0}}, demod_mode};
      default:                    prdata = '0;
    endcase
  end

  assign stage_advance = !audio.valid || audio.ready;
  assign adc.ready     = !stage_valid || stage_advance;
  assign phase_next    = phase_accumulator + phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accumulator <= '0;
      stage_valid       <= 1'b0;
    end else begin
      if (adc.valid && adc.ready) begin
        phase_accumulator <= phase_next;
        stage_valid       <= 1'b1;
      end else if (stage_advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adc.valid && adc.ready) begin
      stage_sample <= adc.adc_sample;
      stage_idx    <= phase_next[ncodm_pkg::PHASE_BITS-1 -: ncodm_pkg::TABLE_BITS];
    end
  end

  always_comb begin
    sample      = signed'({~stage_sample[ncodm_pkg::SAMPLE_BITS-1],
                           stage_sample[ncodm_pkg::SAMPLE_BITS-2:0]});
    lo_i        = ncodm_pkg::sine_value(stage_idx);
    lo_q        = ncodm_pkg::sine_value(stage_idx + ncodm_pkg::QUARTER_OFFSET);
    prod_i      = ncodm_pkg::PROD_BITS'(sample) * ncodm_pkg::PROD_BITS'(lo_i);
    prod_q      = ncodm_pkg::PROD_BITS'(sample) * ncodm_pkg::PROD_BITS'(lo_q);
    diff_i      = (ncodm_pkg::FILT_BITS+1)'(prod_i) - (ncodm_pkg::FILT_BITS+1)'(inphase_filter);
    diff_q      = (ncodm_pkg::FILT_BITS+1)'(prod_q)
                  - (ncodm_pkg::FILT_BITS+1)'(quadrature_filter);
    step_i      = diff_i >>> ncodm_pkg::FILT_SHIFT;
    step_q      = diff_q >>> ncodm_pkg::FILT_SHIFT;
    inphase_next    = inphase_filter + step_i[ncodm_pkg::FILT_BITS-1:0];
    quadrature_next = quadrature_filter + step_q[ncodm_pkg::FILT_BITS-1:0];

    ssb_sum  = (ncodm_pkg::FILT_BITS+1)'(inphase_next)
               + (ncodm_pkg::FILT_BITS+1)'(quadrature_next);
    ssb_diff = (ncodm_pkg::FILT_BITS+1)'(inphase_next)
               - (ncodm_pkg::FILT_BITS+1)'(quadrature_next);
    abs_i    = inphase_next[ncodm_pkg::FILT_BITS-1]
               ? unsigned'(-(ncodm_pkg::FILT_BITS+1)'(inphase_next))
               : unsigned'((ncodm_pkg::FILT_BITS+1)'(inphase_next));
    abs_q    = quadrature_next[ncodm_pkg::FILT_BITS-1]
               ? unsigned'(-(ncodm_pkg::FILT_BITS+1)'(quadrature_next))
               : unsigned'((ncodm_pkg::FILT_BITS+1)'(quadrature_next));
    am_sum   = abs_i + abs_q;

    case (demod_mode)
      ncodm_pkg::MODE_USB: ssb_shifted = ssb_diff >>> ncodm_pkg::SSB_SHIFT;
      ncodm_pkg::MODE_LSB: ssb_shifted = ssb_sum >>> ncodm_pkg::SSB_SHIFT;
      default:             ssb_shifted = signed'(am_sum >> ncodm_pkg::AM_SHIFT);
    endcase
    audio_next = ssb_shifted[ncodm_pkg::AUDIO_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inphase_filter    <= '0;
      quadrature_filter <= '0;
      audio.valid       <= 1'b0;
    end else begin
      if (stage_valid && stage_advance) begin
        inphase_filter    <= inphase_next;
        quadrature_filter <= quadrature_next;
        audio.valid       <= 1'b1;
      end else if (audio.ready) begin
        audio.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_advance) begin
      audio.audio_value <= audio_next;
      audio.pwm_level   <= {~audio_next[ncodm_pkg::PWM_BITS-1],
                            audio_next[ncodm_pkg::PWM_BITS-2:0]};
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] MODE_AM      = 2'd2;
  localparam logic [1:0] MODE_AM_HIGH = 2'd3;
  localparam logic [1:0] MODE_ORDER [4] = '{ncodm_pkg::MODE_USB, ncodm_pkg::MODE_LSB,
                                            MODE_AM, MODE_AM_HIGH};

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;

  typedef struct packed {
    ncodm_pkg::audio_value_t audio;
    ncodm_pkg::pwm_level_t   pwm;
  } demod_result_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ncodm_pkg::ADDR_BITS-1:0] paddr;
  logic [ncodm_pkg::DATA_BITS-1:0] pwdata;
  logic [ncodm_pkg::DATA_BITS-1:0] prdata;
  logic                            pready;

  ncodm_in_if  adc_if ();
  ncodm_out_if audio_if ();

  nco_mixer_ssb_am_demodulator uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .adc     (adc_if),
    .audio   (audio_if)
  );

  int                       lo_table [256];
  logic [31:0]              nco_phase;
  logic [31:0]              nco_step;
  logic [1:0]               demod_mode_cfg;
  ncodm_pkg::filter_value_t i_lpf;
  ncodm_pkg::filter_value_t q_lpf;

  logic [15:0]   tone_phase;
  logic [15:0]   tone_step;
  int            tone_amp;

  demod_result_t demod_expected [$];
  demod_result_t want;
  bit            stalls_on;
  int            mismatches;
  int            results_checked;
  int            samples_sent;
  int            settings_used;
  int unsigned   stall_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int quarter_mag(input int unsigned j);
    longint unsigned x, x2, term, sum_pos, sum_neg, s;
    int k;
    if (j == 0) return 0;
    if (j >= 64) return 127;
    x = (64'(j) * HALF_PI_Q30) / 64'd64;
    x2 = (x * x) >> 30;
    term = x;
    sum_pos = x;
    sum_neg = 64'd0;
    for (k = 1; k <= 9; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum_neg += term;
      else sum_pos += term;
    end
    s = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
    if (s > ONE_Q30) s = ONE_Q30;
    return int'((64'd127 * s) >> 30);
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      if (i < 64) lo_table[i] = quarter_mag(i);
      else if (i < 128) lo_table[i] = quarter_mag(128 - i);
      else if (i < 192) lo_table[i] = -quarter_mag(i - 128);
      else lo_table[i] = -quarter_mag(256 - i);
    end
  end

  function automatic ncodm_pkg::filter_value_t lpf_update(input ncodm_pkg::filter_value_t f,
                                                          input int x);
    int d;
    d = x - int'(f);
    return ncodm_pkg::filter_value_t'(int'(f) + (d >>> ncodm_pkg::FILT_SHIFT));
  endfunction

  function automatic demod_result_t demod_sample(input ncodm_pkg::adc_sample_t raw);
    int            centered, fi, fq, mix;
    logic [7:0]    idx;
    logic [7:0]    qidx;
    demod_result_t r;
    centered = int'(raw) - 2048;
    nco_phase = nco_phase + nco_step;
    idx = nco_phase[31:24];
    qidx = idx + 8'd64;
    i_lpf = lpf_update(i_lpf, centered * lo_table[idx]);
    q_lpf = lpf_update(q_lpf, centered * lo_table[qidx]);
    fi = int'(i_lpf);
    fq = int'(q_lpf);
    if (demod_mode_cfg == ncodm_pkg::MODE_USB) begin
      mix = (fi - fq) >>> ncodm_pkg::SSB_SHIFT;
    end else if (demod_mode_cfg == ncodm_pkg::MODE_LSB) begin
      mix = (fi + fq) >>> ncodm_pkg::SSB_SHIFT;
    end else begin
      mix = ((fi < 0 ? -fi : fi) + (fq < 0 ? -fq : fq)) >>> ncodm_pkg::AM_SHIFT;
    end
    r.audio = ncodm_pkg::audio_value_t'(mix);
    r.pwm = ncodm_pkg::pwm_level_t'(mix + 128);
    return r;
  endfunction

  function automatic ncodm_pkg::adc_sample_t next_sample();
    int s;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      tone_phase = tone_phase + tone_step;
      s = 2048 + lo_table[tone_phase[15:8]] * tone_amp + int'($urandom_range(0, 14)) - 7;
    end else if (pick < 8) begin
      s = $urandom_range(0, 4095);
    end else begin
      case ($urandom_range(0, 3))
        0: s = 0;
        1: s = 4095;
        2: s = 2047;
        default: s = 2048;
      endcase
    end
    return ncodm_pkg::adc_sample_t'(s);
  endfunction

  task automatic start_tone;
    tone_step = nco_step[31:16] + 16'($urandom_range(0, 64)) - 16'd32;
    tone_amp = $urandom_range(1, 16);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_sample(input ncodm_pkg::adc_sample_t s);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      adc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    adc_if.valid <= 1'b1;
    adc_if.adc_sample <= s;
    do @(posedge clk); while (!adc_if.ready);
    demod_expected.push_back(demod_sample(s));
    samples_sent++;
  endtask

  task automatic wait_drained;
    adc_if.valid <= 1'b0;
    while (demod_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ncodm_pkg::ADDR_BITS-1:0] addr,
                            input logic [ncodm_pkg::DATA_BITS-1:0] wdata,
                            output logic [ncodm_pkg::DATA_BITS-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers;
    logic [ncodm_pkg::DATA_BITS-1:0] rd;
    apb_access(1'b0, ncodm_pkg::ADDR_PHASE_STEP, '0, rd);
    if (rd !== nco_step) begin
      note_mismatch($sformatf("phase_step read exp %h got %h", nco_step, rd));
    end
    apb_access(1'b0, ncodm_pkg::ADDR_DEMOD_MODE, '0, rd);
    if (rd !== {30'd0, demod_mode_cfg}) begin
      note_mismatch($sformatf("demod_mode read exp %0d got %h", demod_mode_cfg, rd));
    end
  endtask

  task automatic set_config(input logic [31:0] step_val, input logic [31:0] mode_word);
    logic [ncodm_pkg::DATA_BITS-1:0] rd;
    wait_drained();
    apb_access(1'b1, ncodm_pkg::ADDR_PHASE_STEP, step_val, rd);
    apb_access(1'b1, ncodm_pkg::ADDR_DEMOD_MODE, mode_word, rd);
    nco_step = step_val;
    demod_mode_cfg = mode_word[1:0];
    settings_used++;
    check_registers();
  endtask

  task automatic test_reset_state;
    check_registers();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd2047);
  endtask

  task automatic test_extremes;
    set_config(32'h0100_0000, {30'd0, ncodm_pkg::MODE_USB});
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd2048);
    send_sample(12'd2047);
    send_sample(12'hAAA);
    send_sample(12'h555);
    set_config(32'h4000_0000, {30'd0, ncodm_pkg::MODE_LSB});
    repeat (2) begin
      send_sample(12'd4095);
      send_sample(12'd0);
    end
    set_config(32'hFFFF_FFFF, {30'd0, MODE_AM});
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    set_config(32'h8000_0000, {30'h2AAA_AAAA, MODE_AM_HIGH});
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd1);
  endtask

  task automatic test_filter_limit;
    stalls_on = 1'b1;
    set_config(32'h0, {30'd0, ncodm_pkg::MODE_USB});
    repeat (60) send_sample(12'd0);
    repeat (60) send_sample(12'd4095);
    set_config(32'h0, {30'd0, MODE_AM});
    repeat (40) send_sample(12'd0);
  endtask

  task automatic test_random_traffic;
    logic [31:0] step_val;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: step_val = 32'hFFFF_FFFF;
        1: step_val = 32'h0;
        2: step_val = $urandom_range(1, 32'h0100_0000);
        default: step_val = $urandom;
      endcase
      stalls_on = (p != 3);
      set_config(step_val, {30'($urandom), MODE_ORDER[p % 4]});
      start_tone();
      repeat (180) send_sample(next_sample());
    end
  endtask

  task automatic test_full_rate;
    stalls_on = 1'b0;
    set_config($urandom, {30'($urandom), MODE_ORDER[$urandom_range(0, 3)]});
    start_tone();
    repeat (160) send_sample(next_sample());
  endtask

  initial begin
    audio_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        audio_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      audio_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && audio_if.valid && audio_if.ready) begin
      if (demod_expected.size() == 0) begin
        note_mismatch($sformatf("unexpected item audio=%0d pwm=%0d",
                                audio_if.audio_value, audio_if.pwm_level));
      end else begin
        want = demod_expected.pop_front();
        if (audio_if.audio_value !== want.audio || audio_if.pwm_level !== want.pwm) begin
          note_mismatch($sformatf("item %0d audio exp %0d got %0d, pwm exp %0d got %0d",
                                  results_checked, want.audio, audio_if.audio_value,
                                  want.pwm, audio_if.pwm_level));
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (adc_if.valid && adc_if.ready) || (audio_if.valid && audio_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles at %0t", stall_cycles, $time);
      $display("tb_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    adc_if.valid <= 1'b0;
    adc_if.adc_sample <= '0;
    stalls_on = 1'b0;
    mismatches = 0;
    results_checked = 0;
    samples_sent = 0;
    settings_used = 0;
    nco_phase = '0;
    nco_step = '0;
    demod_mode_cfg = ncodm_pkg::MODE_USB;
    i_lpf = '0;
    q_lpf = '0;
    tone_phase = '0;
    tone_step = '0;
    tone_amp = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_extremes();
    test_filter_limit();
    test_random_traffic();
    test_full_rate();

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d samples and %0d checked results over %0d register settings,",
             samples_sent, results_checked, settings_used);
    $display("all four demodulation modes, phase step extremes and sustained full-scale input");
    if (mismatches == 0 && demod_expected.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, demod_expected.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== nco_mixer_ssb_am_demodulator.f =====
hdl/ncodm_pkg.sv
hdl/ncodm_in_if.sv
hdl/ncodm_out_if.sv
hdl/nco_mixer_ssb_am_demodulator.sv
dv/tb_top.sv
